// ===== rtl/pks_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and helpers for the particle kinematic step block
// no dependencies

package pks_pkg;

	localparam int DT_BITS = 16;
	localparam int MUL_A_W = 50;
	localparam int PROD_W  = 64;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_SET_ACC = 2'd1,
		CMD_TICK    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_LOW_SPEED  = 3'd0,
		REG_MID_SPEED  = 3'd1,
		REG_HIGH_SPEED = 3'd2,
		REG_LOW_LEVEL  = 3'd3,
		REG_MID_LEVEL  = 3'd4,
		REG_HIGH_LEVEL = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_TV, S_TA, S_TAA, S_TD, S_TW,
		S_FSEL, S_SQLO, S_SQHI, S_SQACC, S_SQRT,
		S_RAMP, S_DIVI, S_DIV, S_LVL, S_DONE
	} state_t;

	// clamp a 35-bit signed sum to the 32-bit signed range
	function automatic logic [31:0] sat32(input logic signed [34:0] x);
		logic [31:0] r;
		if (x > 35'sh0_7FFF_FFFF)
			r = 32'h7FFF_FFFF;
		else if (x < -35'sh0_8000_0000)
			r = 32'h8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

// ===== rtl/particle_kinematic_step_with_fade.sv =====
`timescale 1ns / 1ps
// one particle: kinematic update and speed-dependent fade level
// uses pks_pkg (state codes, command codes, saturation)

// Usage
// - input channel in_valid/in_ready carries one command item: load all state,
//   set acceleration, tick by time_step, or an unused code that only reports
// - output channel out_valid/out_ready returns one item per command: position,
//   velocity after the command and a fade level
// - cfg_valid/cfg_ready writes register cfg_index with cfg_data; always ready,
//   indexes above the list are dropped; write only while idle
// - one shared 50x16 multiplier under a sequencer does every product; square
//   root is one bit per cycle, the ramp division one bit per cycle
// - a falling particle skips the square root, a speed outside the ramp skips
//   the division, and a tick first updates each axis in turn
// - in_ready is high only while the sequencer is idle; one item at a time
// - a finished item sits in the output register; the next item may be
//   accepted meanwhile, and if the receiver still stalls at the end of that
//   item the sequencer holds it until the register frees
// - reset zeroes position, velocity, acceleration and loads default registers

module particle_kinematic_step_with_fade
	import pks_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic signed [31:0] load_pos_x,
	input  logic signed [31:0] load_pos_y,
	input  logic signed [31:0] load_pos_z,
	input  logic signed [31:0] load_vel_x,
	input  logic signed [31:0] load_vel_y,
	input  logic signed [31:0] load_vel_z,
	input  logic signed [31:0] load_acc_x,
	input  logic signed [31:0] load_acc_y,
	input  logic signed [31:0] load_acc_z,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_pos_z,
	output logic signed [31:0] out_vel_x,
	output logic signed [31:0] out_vel_y,
	output logic signed [31:0] out_vel_z,
	output logic [15:0]        fade_level,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	state_t state_q, state_d;

	logic [31:0] low_speed_q, mid_speed_q, high_speed_q;
	logic [15:0] low_level_q, mid_level_q, high_level_q;

	logic [31:0] pos_q [3];
	logic [31:0] vel_q [3];
	logic [31:0] acc_q [3];

	logic [1:0]  idx_q;
	logic [4:0]  cnt_q;
	logic [15:0] dt_q;

	logic signed [MUL_A_W-1:0] pv_q, pa_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [33:0]        dpos_q, dvel_q;

	logic [63:0] sum_q;
	logic [63:0] rad_q;
	logic [33:0] srem_q;
	logic [31:0] root_q;
	logic [31:0] s_q;

	logic [31:0] lo_q, hi_q, span_q;
	logic [15:0] start_q, end_q, level_q;
	logic        up_q;
	logic [32:0] rem_q;
	logic [15:0] nbits_q, quo_q;

	logic                      out_valid_q;
	logic                      out_free;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [15:0]               mul_b;
	logic signed [66:0]        mul_p;
	logic [31:0]               vmag;
	logic [31:0]               ramp_t;
	logic [15:0]               ramp_d;
	logic                      ramp_below, ramp_above, ramp_empty;
	logic                      accept;

	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	// magnitude of the current velocity component
	assign vmag = vel_q[idx_q][31] ? (~vel_q[idx_q] + 32'd1) : vel_q[idx_q];

	assign ramp_below = s_q < lo_q;
	assign ramp_above = s_q > hi_q;
	assign ramp_empty = hi_q == lo_q;
	assign ramp_t     = s_q - lo_q;
	assign ramp_d     = (end_q >= start_q) ? (end_q - start_q) : (start_q - end_q);

	// shared multiplier
	assign mul_p = mul_a * $signed({1'b0, mul_b});

	always_comb begin
		in_ready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_TV: begin
				mul_a = MUL_A_W'($signed(vel_q[idx_q]));
				mul_b = dt_q;
			end
			S_TA: begin
				mul_a = MUL_A_W'($signed(acc_q[idx_q]));
				mul_b = dt_q;
			end
			S_TAA: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = dt_q;
			end
			S_SQLO: begin
				mul_a = MUL_A_W'({1'b0, vmag});
				mul_b = vmag[15:0];
			end
			S_SQHI: begin
				mul_a = MUL_A_W'({1'b0, vmag});
				mul_b = vmag[31:16];
			end
			S_RAMP: begin
				mul_a = MUL_A_W'({1'b0, ramp_t});
				mul_b = ramp_d;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = (cmd_t'(command) == CMD_TICK) ? S_TV : S_FSEL;
			end
			S_TV:   state_d = S_TA;
			S_TA:   state_d = S_TAA;
			S_TAA:  state_d = S_TD;
			S_TD:   state_d = S_TW;
			S_TW:   state_d = (idx_q == 2'd2) ? S_FSEL : S_TV;
			S_FSEL: state_d = vel_q[1][31] ? S_RAMP : S_SQLO;
			S_SQLO: state_d = S_SQHI;
			S_SQHI: state_d = S_SQACC;
			S_SQACC: state_d = (idx_q == 2'd2) ? S_SQRT : S_SQLO;
			S_SQRT: state_d = (cnt_q == 5'd31) ? S_RAMP : S_SQRT;
			S_RAMP: state_d = (ramp_below || ramp_above || ramp_empty) ? S_DONE : S_DIVI;
			S_DIVI: state_d = S_DIV;
			S_DIV:  state_d = (cnt_q == 5'd15) ? S_LVL : S_DIV;
			S_LVL:  state_d = S_DONE;
			S_DONE: state_d = out_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_speed_q  <= 32'd65536;
			mid_speed_q  <= 32'd131072;
			high_speed_q <= 32'd655360;
			low_level_q  <= 16'd16384;
			mid_level_q  <= 16'd32768;
			high_level_q <= 16'd65535;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOW_SPEED:  low_speed_q  <= cfg_data;
				REG_MID_SPEED:  mid_speed_q  <= cfg_data;
				REG_HIGH_SPEED: high_speed_q <= cfg_data;
				REG_LOW_LEVEL:  low_level_q  <= cfg_data[15:0];
				REG_MID_LEVEL:  mid_level_q  <= cfg_data[15:0];
				REG_HIGH_LEVEL: high_level_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// particle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else if (accept && cmd_t'(command) == CMD_LOAD) begin
			pos_q[0] <= load_pos_x;
			pos_q[1] <= load_pos_y;
			pos_q[2] <= load_pos_z;
			vel_q[0] <= load_vel_x;
			vel_q[1] <= load_vel_y;
			vel_q[2] <= load_vel_z;
			acc_q[0] <= load_acc_x;
			acc_q[1] <= load_acc_y;
			acc_q[2] <= load_acc_z;
		end else if (accept && cmd_t'(command) == CMD_SET_ACC) begin
			acc_q[0] <= load_acc_x;
			acc_q[1] <= load_acc_y;
			acc_q[2] <= load_acc_z;
		end else if (state_q == S_TW) begin
			pos_q[idx_q] <= sat32(35'($signed(pos_q[idx_q])) + 35'(dpos_q));
			vel_q[idx_q] <= sat32(35'($signed(vel_q[idx_q])) + 35'(dvel_q));
		end
	end

	// sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE, S_FSEL: idx_q <= '0;
				S_TW, S_SQACC:  idx_q <= idx_q + 2'd1;
				S_SQRT, S_DIV:  cnt_q <= cnt_q + 5'd1;
				default: cnt_q <= '0;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p[PROD_W-1:0];
		case (state_q)
			S_IDLE: dt_q <= time_step;
			S_TA:   pv_q <= prod_q[MUL_A_W-1:0];
			S_TAA:  pa_q <= prod_q[MUL_A_W-1:0];
			S_TD: begin
				dpos_q <= 34'((64'(pv_q) + (prod_q >>> (DT_BITS + 1)) + 64'sd32768) >>> DT_BITS);
				dvel_q <= 34'((64'(pa_q) + 64'sd32768) >>> DT_BITS);
			end
			S_FSEL: begin
				sum_q <= '0;
				if (vel_q[1][31]) begin
					s_q     <= ~vel_q[1] + 32'd1;
					lo_q    <= mid_speed_q;
					hi_q    <= high_speed_q;
					start_q <= mid_level_q;
					end_q   <= low_level_q;
				end
			end
			S_SQHI:  sum_q <= sum_q + prod_q[63:0];
			S_SQACC: begin
				sum_q  <= sum_q + {prod_q[47:0], 16'd0};
				rad_q  <= sum_q + {prod_q[47:0], 16'd0};
				srem_q <= '0;
				root_q <= '0;
			end
			S_SQRT: begin
				// one root bit per cycle, two radicand bits in
				if ({srem_q[31:0], rad_q[63:62]} >= {root_q, 2'b01}) begin
					srem_q <= {srem_q[31:0], rad_q[63:62]} - {root_q, 2'b01};
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					srem_q <= {srem_q[31:0], rad_q[63:62]};
					root_q <= {root_q[30:0], 1'b0};
				end
				rad_q <= {rad_q[61:0], 2'b00};
				if (cnt_q == 5'd31) begin
					s_q     <= ({srem_q[31:0], rad_q[63:62]} >= {root_q, 2'b01}) ?
						{root_q[30:0], 1'b1} : {root_q[30:0], 1'b0};
					lo_q    <= low_speed_q;
					hi_q    <= high_speed_q;
					start_q <= mid_level_q;
					end_q   <= high_level_q;
				end
			end
			S_RAMP: begin
				span_q <= hi_q - lo_q;
				up_q   <= end_q >= start_q;
				if (ramp_below)
					level_q <= start_q;
				else if (ramp_above)
					level_q <= end_q;
				else if (ramp_empty)
					level_q <= start_q;
			end
			S_DIVI: begin
				// quotient fits 16 bits, so the top part is already below the span
				rem_q   <= 33'((49'(prod_q[47:0]) + 49'(span_q[31:1])) >> 16);
				nbits_q <= 16'({1'b0, prod_q[15:0]} + {1'b0, span_q[16:1]});
				quo_q   <= '0;
			end
			S_DIV: begin
				if ({rem_q[31:0], nbits_q[15]} >= {1'b0, span_q}) begin
					rem_q <= {rem_q[31:0], nbits_q[15]} - {1'b0, span_q};
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= {rem_q[31:0], nbits_q[15]};
					quo_q <= {quo_q[14:0], 1'b0};
				end
				nbits_q <= {nbits_q[14:0], 1'b0};
			end
			S_LVL: level_q <= up_q ? (start_q + quo_q) : (start_q - quo_q);
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_DONE && out_free)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_pos_x  <= pos_q[0];
			out_pos_y  <= pos_q[1];
			out_pos_z  <= pos_q[2];
			out_vel_x  <= vel_q[0];
			out_vel_y  <= vel_q[1];
			out_vel_z  <= vel_q[2];
			fade_level <= level_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_t'(command) == CMD_TICK |=> state_q == S_TV)
		else $error("tick item did not start the update sequence");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < {1'b0, span_q})
		else $error("division remainder not below span");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LVL |-> quo_q <= ramp_d)
		else $error("ramp quotient exceeds level difference");
`endif

endmodule
